/* sv/nfa_pkg.sv */
package nfa_pkg;

  // Field widths of one request and one result
  localparam int OP_W     = 2;
  localparam int SLOT_W   = 6;
  localparam int TAG_W    = 8;
  localparam int PARENT_W = 7;

  typedef enum logic [OP_W-1:0] {
    OP_ALLOC   = 2'd0,
    OP_RELEASE = 2'd1,
    OP_REAP    = 2'd2,
    OP_QUERY   = 2'd3
  } op_e;

  typedef struct packed {
    op_e               operation;
    logic [SLOT_W-1:0] slot_id;
    logic [SLOT_W-1:0] parent_id;
    logic [TAG_W-1:0]  owner_tag;
  } req_t;

  typedef struct packed {
    logic [SLOT_W-1:0] granted_slot;
    logic              status;
    logic              table_full;
  } rsp_t;

endpackage

/* sv/nfa_if.sv */
interface nfa_req_if;
  logic          valid;
  logic          ready;
  nfa_pkg::req_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

interface nfa_rsp_if;
  logic          valid;
  logic          ready;
  nfa_pkg::rsp_t payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

/* sv/nfa_slot_mem.sv */
// Slot bitmap store: one row holds the valid bits and the identifier marks of a group of slots.
module nfa_slot_mem #(
  parameter int W     = 128,
  parameter int DEPTH = 2
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [W-1:0]             wr_data_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(DEPTH)-1:0] rd_addr_i,
  output logic [W-1:0]             rd_data_o
);

  logic [W-1:0] mem_q [DEPTH];
  logic [W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Hold the last read word until the next read
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

/* sv/nfa_rec_mem.sv */
// Per-slot record of parent and owner, written when a slot is claimed.
module nfa_rec_mem #(
  parameter int W     = 15,
  parameter int DEPTH = 128
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_addr_i,
  input  logic [W-1:0]             wr_data_i
);

  logic [W-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

endmodule

/* sv/nfa_pick.sv */
// Lowest set bit of a row mask.
module nfa_pick #(
  parameter int W = 64
) (
  input  logic [W-1:0]         mask_i,
  output logic                 found_o,
  output logic [$clog2(W)-1:0] idx_o
);

  localparam int IW = $clog2(W);

  always_comb begin
    idx_o = '0;
    for (int b = W - 1; b >= 0; b--) begin
      if (mask_i[b]) begin
        idx_o = IW'(b);
      end
    end
  end

  assign found_o = |mask_i;

endmodule

/* sv/next_fit_process_slot_allocator.sv */
// Release, reap and query: addressed row read on accept, result registered when the output is free.
// Allocate: one bitmap memory row (up to 64 slots) read per cycle while searching,
// up to ROWS+1 rows visited, the start row twice; ROWS = ceil(SLOTS/64).
// A new request is taken once the previous one has left the lookup state.
// Reset: rows never written read as their reset contents (slot 0 valid and taken),
// so no clearing pass runs; the search pointer resets to 1.
module next_fit_process_slot_allocator #(
  parameter int SLOTS = 64
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  nfa_req_if.sink          req_i,
  nfa_rsp_if.source        rsp_o
);

  localparam int SW    = $clog2(SLOTS);
  localparam int ROW_W = (SLOTS >= 64) ? 64 : (1 << SW);
  localparam int BW    = $clog2(ROW_W);
  localparam int ROWS  = (SLOTS + ROW_W - 1) / ROW_W;
  localparam int RW    = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int DEPTH = 1 << RW;
  localparam int XW    = RW + BW;
  localparam int EW    = XW + nfa_pkg::SLOT_W;
  localparam int CW    = $clog2(SLOTS + 1);
  localparam int VW    = $clog2(ROWS + 2);
  localparam int RECW  = nfa_pkg::PARENT_W + nfa_pkg::TAG_W;

  typedef enum logic [1:0] {
    ST_IDLE = 2'b01,
    ST_LOOK = 2'b10
  } state_e;

  state_e                      state_q, state_d;
  nfa_pkg::op_e                op_q;
  logic [BW-1:0]               bit_q;
  logic                        sok_q;
  logic [BW-1:0]               lo_q;
  logic [nfa_pkg::SLOT_W-1:0]  par_q;
  logic [nfa_pkg::TAG_W-1:0]   tag_q;
  logic [RW-1:0]               row_q, row_d;
  logic [VW-1:0]               visit_q, visit_d;
  logic [nfa_pkg::SLOT_W-1:0]  ns_q, ns_d;
  logic [CW-1:0]               vcnt_q, vcnt_d;
  logic [DEPTH-1:0]            rinit_q;
  logic                        out_valid_q;
  nfa_pkg::rsp_t               out_q, out_d;

  logic                        req_fire;
  logic [EW-1:0]               sid_ext, ns_ext;
  logic [XW-1:0]               sid_x, start_x;
  logic                        sid_ok;

  logic                        rd_en, wr_en, rec_en;
  logic [RW-1:0]               rd_row;
  logic [2*ROW_W-1:0]          rd_word, wr_word, cur_word;
  logic [ROW_W-1:0]            rst_half, v_row, t_row, mask, hit_oh, sid_oh;
  logic                        found;
  logic [BW-1:0]               hit;
  logic [XW-1:0]               gslot;
  logic [XW:0]                 gnext, nx;
  logic [XW+nfa_pkg::SLOT_W:0] nx_wide;
  logic [EW-1:0]               g_wide;
  logic                        is_alloc, last, done, out_free, complete, step;

  assign req_fire = req_i.valid && req_i.ready;
  assign req_i.ready = (state_q == ST_IDLE);

  // Map request slot and search pointer onto the internal slot index
  assign sid_ext = {{XW{1'b0}}, req_i.payload.slot_id};
  assign sid_x   = sid_ext[XW-1:0];
  assign sid_ok  = sid_ext < EW'(SLOTS);
  assign ns_ext  = {{XW{1'b0}}, ns_q};
  assign start_x = (ns_q != '0 && ns_ext < EW'(SLOTS)) ? ns_ext[XW-1:0] : XW'(1);

  // Unwritten rows read as reset contents
  assign rst_half = (row_q == '0) ? ROW_W'(1) : '0;
  assign cur_word = rinit_q[row_q] ? rd_word : {rst_half, rst_half};
  assign v_row    = cur_word[2*ROW_W-1:ROW_W];
  assign t_row    = cur_word[ROW_W-1:0];

  always_comb begin
    logic [XW-1:0] slot_b;
    for (int b = 0; b < ROW_W; b++) begin
      slot_b  = {row_q, BW'(b)};
      mask[b] = !t_row[b] && (slot_b != '0) && ({1'b0, slot_b} < (XW+1)'(SLOTS))
                && ((visit_q != '0) || (BW'(b) >= lo_q));
    end
  end

  nfa_pick #(.W(ROW_W)) u_pick (
    .mask_i  (mask),
    .found_o (found),
    .idx_o   (hit)
  );

  assign gslot   = {row_q, hit};
  assign gnext   = {1'b0, gslot} + (XW+1)'(1);
  assign nx      = (gnext >= (XW+1)'(SLOTS)) ? (XW+1)'(1) : gnext;
  assign nx_wide = {{nfa_pkg::SLOT_W{1'b0}}, nx};
  assign g_wide  = {{nfa_pkg::SLOT_W{1'b0}}, gslot};
  assign hit_oh  = ROW_W'(1) << hit;
  assign sid_oh  = ROW_W'(1) << bit_q;

  assign is_alloc = (op_q == nfa_pkg::OP_ALLOC);
  assign last     = (visit_q == VW'(ROWS));
  assign done     = !is_alloc || found || last;
  assign out_free = !out_valid_q || rsp_o.ready;
  assign complete = (state_q == ST_LOOK) && done && out_free;
  assign step     = (state_q == ST_LOOK) && !done;

  // Row read: start or addressed row on accept, next row while searching
  always_comb begin
    rd_en   = 1'b0;
    rd_row  = row_q;
    row_d   = row_q;
    visit_d = visit_q;
    if (req_fire) begin
      rd_en   = 1'b1;
      rd_row  = (req_i.payload.operation == nfa_pkg::OP_ALLOC) ?
                start_x[XW-1:BW] : sid_x[XW-1:BW];
      row_d   = rd_row;
      visit_d = '0;
    end else if (step) begin
      rd_en   = 1'b1;
      rd_row  = (row_q == RW'(ROWS - 1)) ? '0 : row_q + RW'(1);
      row_d   = rd_row;
      visit_d = visit_q + VW'(1);
    end
  end

  // Modify and write back the row, build the result
  always_comb begin
    wr_en   = 1'b0;
    rec_en  = 1'b0;
    wr_word = cur_word;
    vcnt_d  = vcnt_q;
    ns_d    = ns_q;
    out_d   = '0;
    unique case (op_q)
      nfa_pkg::OP_ALLOC: begin
        if (found) begin
          wr_en              = complete;
          rec_en             = complete;
          wr_word            = {v_row | hit_oh, t_row | hit_oh};
          out_d.granted_slot = g_wide[nfa_pkg::SLOT_W-1:0];
          if (complete) begin
            ns_d = nx_wide[nfa_pkg::SLOT_W-1:0];
            if (!v_row[hit]) begin
              vcnt_d = vcnt_q + CW'(1);
            end
          end
        end else begin
          out_d.status = 1'b1;
        end
      end
      nfa_pkg::OP_RELEASE: begin
        wr_en   = complete && sok_q;
        wr_word = {v_row & ~sid_oh, t_row};
        if (complete && sok_q && v_row[bit_q]) begin
          vcnt_d = vcnt_q - CW'(1);
        end
      end
      nfa_pkg::OP_REAP: begin
        wr_en   = complete && sok_q;
        wr_word = {v_row, t_row & ~sid_oh};
      end
      nfa_pkg::OP_QUERY: begin
        out_d.table_full = (vcnt_q == CW'(SLOTS));
      end
    endcase
  end

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (req_fire) begin
          state_d = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (complete) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      row_q       <= '0;
      visit_q     <= '0;
      ns_q        <= nfa_pkg::SLOT_W'(1);
      vcnt_q      <= CW'(1);
      rinit_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      row_q   <= row_d;
      visit_q <= visit_d;
      ns_q    <= ns_d;
      vcnt_q  <= vcnt_d;
      if (wr_en) begin
        rinit_q[row_q] <= 1'b1;
      end
      if (complete) begin
        out_valid_q <= 1'b1;
      end else if (rsp_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request fields and result payload
  always_ff @(posedge clk_i) begin
    if (req_fire) begin
      op_q  <= req_i.payload.operation;
      bit_q <= sid_x[BW-1:0];
      sok_q <= sid_ok;
      lo_q  <= start_x[BW-1:0];
      par_q <= req_i.payload.parent_id;
      tag_q <= req_i.payload.owner_tag;
    end
    if (complete) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  nfa_slot_mem #(.W(2 * ROW_W), .DEPTH(DEPTH)) u_slot_mem (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (row_q),
    .wr_data_i (wr_word),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_row),
    .rd_data_o (rd_word)
  );

  nfa_rec_mem #(.W(RECW), .DEPTH(1 << XW)) u_rec_mem (
    .clk_i     (clk_i),
    .wr_en_i   (rec_en),
    .wr_addr_i (gslot),
    .wr_data_i ({1'b0, par_q, tag_q})
  );

endmodule

/* sv/nfa_chk.sv */
module nfa_chk #(
  parameter int SLOTS = 64
) (
  input logic          clk_i,
  input logic          rst_ni,
  input logic          req_valid_i,
  input logic          req_ready_i,
  input logic          rsp_valid_i,
  input logic          rsp_ready_i,
  input nfa_pkg::rsp_t rsp_payload_i
);

  // Hold a stalled result
  a_rsp_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i && $stable(rsp_payload_i))
    else $error("result changed while stalled");

  // One request in lookup at a time
  a_req_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid_i && req_ready_i |=> !req_ready_i)
    else $error("request taken during lookup");

  a_fail_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_payload_i.status |->
      rsp_payload_i.granted_slot == '0 && !rsp_payload_i.table_full)
    else $error("failed allocate carries a slot or full flag");

  a_full_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && rsp_payload_i.table_full |-> rsp_payload_i.granted_slot == '0)
    else $error("query result carries a slot");

  a_slot_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> (SLOTS > 64) || (int'(rsp_payload_i.granted_slot) < SLOTS))
    else $error("granted slot out of range");

endmodule

bind next_fit_process_slot_allocator nfa_chk #(.SLOTS(SLOTS)) u_nfa_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .req_valid_i   (req_i.valid),
  .req_ready_i   (req_i.ready),
  .rsp_valid_i   (rsp_o.valid),
  .rsp_ready_i   (rsp_o.ready),
  .rsp_payload_i (rsp_o.payload)
);
